// ===== rtl/scpf_pkg.sv =====
// shared types and constants for the servo command packet framer
`timescale 1ns / 1ps

package scpf_pkg;

  // command kinds as carried on in_tuser
  typedef enum logic [2:0] {
    KIND_PING      = 3'd0,
    KIND_RESET     = 3'd1,
    KIND_SET_ID    = 3'd2,
    KIND_STATUS    = 3'd3,
    KIND_BAUD      = 3'd4,
    KIND_GOAL_POS  = 3'd5,
    KIND_MOVE_SPD  = 3'd6,
    KIND_UNUSED    = 3'd7
  } kind_t;

  // packet bytes
  localparam logic [7:0] START_MARK        = 8'hFF;
  localparam logic [7:0] INSTR_PING        = 8'h01;
  localparam logic [7:0] INSTR_WRITE       = 8'h03;
  localparam logic [7:0] INSTR_RESET       = 8'h06;
  localparam logic [7:0] ADDR_ID           = 8'h03;
  localparam logic [7:0] ADDR_BAUD         = 8'h04;
  localparam logic [7:0] ADDR_STATUS_LEVEL = 8'h10;
  localparam logic [7:0] ADDR_GOAL_POS     = 8'h1E;
  localparam logic [7:0] ADDR_MOVE_SPEED   = 8'h20;

  // argument limits
  localparam logic [9:0] BYTE_MAX     = 10'd255;
  localparam logic [9:0] STATUS_MAX   = 10'd2;

  // start, start, id, length, instruction come before the parameters
  localparam int         HDR_BYTES    = 5;
  localparam int         IDX_W        = 4;

  // byte positions inside a packet
  localparam logic [IDX_W-1:0] POS_START0 = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_START1 = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_ID     = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_LEN    = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_INSTR  = IDX_W'(4);
  localparam logic [IDX_W-1:0] POS_P0     = IDX_W'(5);
  localparam logic [IDX_W-1:0] POS_P1     = IDX_W'(6);
  localparam logic [IDX_W-1:0] POS_P2     = IDX_W'(7);
  localparam logic [IDX_W-1:0] POS_MAX    = IDX_W'(8);

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one classified command, ready to serialize
  typedef struct packed {
    logic       reject;
    logic [1:0] nparam;
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] instr;
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
    logic [7:0] ck;
  } desc_t;

endpackage

// ===== rtl/scpf_front.sv =====
// front end: accepts commands, checks arguments, builds packet descriptors
`timescale 1ns / 1ps

module scpf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [2:0]           in_kind,
  input  logic [7:0]           in_servo_id,
  input  logic [9:0]           in_value,
  output logic                 push_valid,
  input  logic                 push_ready,
  output scpf_pkg::desc_t      push_desc
);

  logic            valid_r;
  logic            valid_nxt;
  scpf_pkg::desc_t desc_r;
  scpf_pkg::desc_t desc_nxt;
  logic            take;

  assign in_tready  = !valid_r || push_ready;
  assign take       = in_tvalid && in_tready;
  assign push_valid = valid_r;
  assign push_desc  = desc_r;

  always_comb begin
    desc_nxt        = '0;
    desc_nxt.id     = in_servo_id;
    desc_nxt.instr  = scpf_pkg::INSTR_WRITE;
    case (scpf_pkg::kind_t'(in_kind))
      scpf_pkg::KIND_PING: begin
        desc_nxt.instr = scpf_pkg::INSTR_PING;
      end
      scpf_pkg::KIND_RESET: begin
        desc_nxt.instr = scpf_pkg::INSTR_RESET;
      end
      scpf_pkg::KIND_SET_ID: begin
        desc_nxt.reject = in_value > scpf_pkg::BYTE_MAX;
        desc_nxt.p0     = scpf_pkg::ADDR_ID;
        desc_nxt.p1     = in_value[7:0];
        desc_nxt.nparam = 2'd2;
      end
      scpf_pkg::KIND_STATUS: begin
        desc_nxt.reject = in_value > scpf_pkg::STATUS_MAX;
        desc_nxt.p0     = scpf_pkg::ADDR_STATUS_LEVEL;
        desc_nxt.p1     = in_value[7:0];
        desc_nxt.nparam = 2'd2;
      end
      scpf_pkg::KIND_BAUD: begin
        desc_nxt.reject = in_value > scpf_pkg::BYTE_MAX;
        desc_nxt.p0     = scpf_pkg::ADDR_BAUD;
        desc_nxt.p1     = in_value[7:0];
        desc_nxt.nparam = 2'd2;
      end
      scpf_pkg::KIND_GOAL_POS: begin
        desc_nxt.p0     = scpf_pkg::ADDR_GOAL_POS;
        desc_nxt.p1     = in_value[7:0];
        desc_nxt.p2     = {6'd0, in_value[9:8]};
        desc_nxt.nparam = 2'd3;
      end
      scpf_pkg::KIND_MOVE_SPD: begin
        desc_nxt.reject = in_value == 10'd0;
        desc_nxt.p0     = scpf_pkg::ADDR_MOVE_SPEED;
        desc_nxt.p1     = in_value[7:0];
        desc_nxt.p2     = {6'd0, in_value[9:8]};
        desc_nxt.nparam = 2'd3;
      end
      default: begin
        desc_nxt.reject = 1'b1;
      end
    endcase
    // unused parameters stay zero, so they drop out of the sum
    desc_nxt.len = {6'd0, desc_nxt.nparam} + 8'd2;
    desc_nxt.ck  = ~(desc_nxt.id + desc_nxt.len + desc_nxt.instr
                     + desc_nxt.p0 + desc_nxt.p1 + desc_nxt.p2);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      desc_r <= desc_nxt;
    end
  end

endmodule

// ===== rtl/scpf_queue.sv =====
// short descriptor queue between front end and serializer
`timescale 1ns / 1ps

module scpf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  scpf_pkg::desc_t      push_desc,
  output logic                 pop_valid,
  input  logic                 pop,
  output scpf_pkg::desc_t      pop_desc
);

  localparam logic [scpf_pkg::QPTR_W-1:0] PTR_LAST = scpf_pkg::QPTR_W'(scpf_pkg::QDEPTH - 1);
  localparam logic [scpf_pkg::QCNT_W-1:0] CNT_FULL = scpf_pkg::QCNT_W'(scpf_pkg::QDEPTH);

  scpf_pkg::desc_t               mem [scpf_pkg::QDEPTH];
  logic [scpf_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [scpf_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [scpf_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = count_r != CNT_FULL;
  assign pop_valid  = count_r != '0;
  assign pop_desc   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== rtl/scpf_back.sv =====
// serializer: head descriptor to output register, one byte per cycle unless stalled
`timescale 1ns / 1ps

module scpf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  scpf_pkg::desc_t      q_desc,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast,
  output logic [0:0]           out_tuser
);

  logic [scpf_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [scpf_pkg::IDX_W-1:0] final_idx;
  logic                       out_valid_r, out_valid_nxt;
  logic [7:0]                 out_byte_r;
  logic                       out_last_r;
  logic                       out_rej_r;
  logic [7:0]                 byte_sel;
  logic                       is_final;
  logic                       adv;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_rej_r;

  assign adv       = q_valid && (!out_valid_r || out_tready);
  assign final_idx = scpf_pkg::IDX_W'(scpf_pkg::HDR_BYTES)
                   + {{(scpf_pkg::IDX_W-2){1'b0}}, q_desc.nparam};
  assign is_final  = q_desc.reject || (idx_r == final_idx);
  assign q_pop     = adv && is_final;

  always_comb begin
    byte_sel = 8'd0;
    if (q_desc.reject) begin
      byte_sel = 8'd0;
    end else if (idx_r == final_idx) begin
      byte_sel = q_desc.ck;
    end else begin
      case (idx_r)
        scpf_pkg::POS_START0: byte_sel = scpf_pkg::START_MARK;
        scpf_pkg::POS_START1: byte_sel = scpf_pkg::START_MARK;
        scpf_pkg::POS_ID:     byte_sel = q_desc.id;
        scpf_pkg::POS_LEN:    byte_sel = q_desc.len;
        scpf_pkg::POS_INSTR:  byte_sel = q_desc.instr;
        scpf_pkg::POS_P0:     byte_sel = q_desc.p0;
        scpf_pkg::POS_P1:     byte_sel = q_desc.p1;
        scpf_pkg::POS_P2:     byte_sel = q_desc.p2;
        default:              byte_sel = 8'd0;
      endcase
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      idx_nxt       = is_final ? '0 : idx_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= byte_sel;
      out_last_r <= is_final;
      out_rej_r  <= q_desc.reject;
    end
  end

  // byte position never runs past the longest packet
  assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= scpf_pkg::POS_MAX)
    else $error("byte index past end of packet");

  // mid-packet the head descriptor must still be in the queue
  assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> q_valid)
    else $error("descriptor left queue before packet finished");

  // a reject result is a single zero byte marked last
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rej_r) |-> (out_last_r && out_byte_r == 8'd0))
    else $error("reject result malformed");

endmodule

// ===== rtl/servo_command_packet_framer_core.sv =====
// top level of the servo command packet framer
`timescale 1ns / 1ps

// turns one servo command into an instruction packet streamed one byte per transaction
// input channel: in_tuser carries the command kind, in_tdata the servo id and value
// output channel: out_tdata is the packet byte, out_tlast marks the checksum byte,
//   out_tuser flags a rejected command, sent as a single zero byte with out_tlast set
// packet: ff ff id length instruction params checksum, 6, 8 or 9 bytes per command
// the first byte of a command passes the front register, a queue write and the output register
//   before it shows on out_tvalid
// throughput: one byte per cycle from the serializer while out_tready allows it,
//   and packets follow without gaps
// the front end keeps taking commands while the serializer works, until its register
//   and the two-entry queue are full
// when out_tready is low the output register holds its byte and the serializer waits;
//   backpressure reaches in_tready only once the queue fills
// reset clears the valid flags, queue pointers and byte index; no transaction in
//   flight survives a reset
module servo_command_packet_framer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] servo_id, [17:8] value, [23:18] zero
  input  logic [2:0]  in_tuser,   // [2:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] tx_byte
  output logic        out_tlast,
  output logic [0:0]  out_tuser   // [0] rejected
);

  // front end to queue
  logic            push_valid;
  logic            push_ready;
  scpf_pkg::desc_t push_desc;

  // queue to serializer
  logic            q_valid;
  logic            q_pop;
  scpf_pkg::desc_t q_desc;

  // classify the command and precompute length and checksum
  scpf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_kind     (in_tuser),
    .in_servo_id (in_tdata[7:0]),
    .in_value    (in_tdata[17:8]),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_desc   (push_desc)
  );

  // decouples command intake from byte streaming
  scpf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_desc   (q_desc)
  );

  // streams the head descriptor byte by byte
  scpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_desc     (q_desc),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== dv/servo_command_packet_framer_core_test.sv =====
// self-checking testbench for the servo command packet framer core
`timescale 1ns / 1ps

module servo_command_packet_framer_core_test;

  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int DRAIN_CYCLES     = 20;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int MAX_PRINTED      = 100;

  // one expected byte of the outgoing stream
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       rej;
  } packet_byte_t;

  // predicts the packet for each accepted command and checks bytes in order
  class packet_scoreboard;
    packet_byte_t expected_bytes[$];
    int errors     = 0;
    int n_commands = 0;
    int n_packets  = 0;
    int n_rejects  = 0;
    int n_bytes    = 0;

    function int pending();
      return expected_bytes.size();
    endfunction

    function void queue_byte(logic [7:0] data, logic last, logic rej);
      packet_byte_t pb;
      pb.data = data;
      pb.last = last;
      pb.rej  = rej;
      expected_bytes.push_back(pb);
    endfunction

    // builds the instruction packet, or a single reject byte
    function void note_command(scpf_pkg::kind_t kind, logic [7:0] sid, logic [9:0] value);
      logic [7:0] instr;
      logic [7:0] len;
      logic [7:0] sum;
      logic [7:0] params [3];
      int         nparam;
      logic       refuse;
      instr     = scpf_pkg::INSTR_WRITE;
      nparam    = 0;
      refuse    = 1'b0;
      params[0] = 8'h00;
      params[1] = value[7:0];
      params[2] = {6'b0, value[9:8]};
      case (kind)
        scpf_pkg::KIND_PING: instr = scpf_pkg::INSTR_PING;
        scpf_pkg::KIND_RESET: instr = scpf_pkg::INSTR_RESET;
        scpf_pkg::KIND_SET_ID: begin
          refuse    = value > scpf_pkg::BYTE_MAX;
          params[0] = scpf_pkg::ADDR_ID;
          nparam    = 2;
        end
        scpf_pkg::KIND_STATUS: begin
          refuse    = value > scpf_pkg::STATUS_MAX;
          params[0] = scpf_pkg::ADDR_STATUS_LEVEL;
          nparam    = 2;
        end
        scpf_pkg::KIND_BAUD: begin
          refuse    = value > scpf_pkg::BYTE_MAX;
          params[0] = scpf_pkg::ADDR_BAUD;
          nparam    = 2;
        end
        scpf_pkg::KIND_GOAL_POS: begin
          params[0] = scpf_pkg::ADDR_GOAL_POS;
          nparam    = 3;
        end
        scpf_pkg::KIND_MOVE_SPD: begin
          refuse    = (value == 10'd0);
          params[0] = scpf_pkg::ADDR_MOVE_SPEED;
          nparam    = 3;
        end
        default: refuse = 1'b1;
      endcase
      n_commands++;
      if (refuse) begin
        n_rejects++;
        queue_byte(8'h00, 1'b1, 1'b1);
        return;
      end
      n_packets++;
      len = 8'(nparam + 2);
      sum = sid + len + instr;
      queue_byte(scpf_pkg::START_MARK, 1'b0, 1'b0);
      queue_byte(scpf_pkg::START_MARK, 1'b0, 1'b0);
      queue_byte(sid, 1'b0, 1'b0);
      queue_byte(len, 1'b0, 1'b0);
      queue_byte(instr, 1'b0, 1'b0);
      for (int i = 0; i < nparam; i++) begin
        queue_byte(params[i], 1'b0, 1'b0);
        sum = sum + params[i];
      end
      queue_byte(~sum, 1'b1, 1'b0);
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    task check_byte(logic [7:0] data, logic last, logic rej);
      packet_byte_t want;
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected byte", data, 0);
        return;
      end
      want = expected_bytes.pop_front();
      n_bytes++;
      if (data !== want.data) report_mismatch("tx_byte", data, want.data);
      if (last !== want.last) report_mismatch("last", last, want.last);
      if (rej !== want.rej) report_mismatch("rejected", rej, want.rej);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;

  packet_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  servo_command_packet_framer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver backpressure, redrawn every cycle
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // byte monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_byte(out_tdata, out_tlast, out_tuser[0]);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d bytes still expected", sb.pending());
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one command and hold it until the transaction completes
  task send_command(scpf_pkg::kind_t kind, logic [7:0] sid, logic [9:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'b0, value, sid};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(kind, sid, value);
  endtask

  // sender goes quiet until every expected byte has come out
  task wait_for_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task send_random_command();
    scpf_pkg::kind_t kind;
    logic [9:0]      value;
    if ($urandom_range(99) < 4) kind = scpf_pkg::KIND_UNUSED;
    else kind = scpf_pkg::kind_t'(3'($urandom_range(6)));
    case (kind)
      scpf_pkg::KIND_SET_ID, scpf_pkg::KIND_BAUD: begin
        if ($urandom_range(9) < 8) value = 10'($urandom_range(255));
        else value = 10'($urandom_range(1023, 256));
      end
      scpf_pkg::KIND_STATUS: begin
        if ($urandom_range(9) < 8) value = 10'($urandom_range(2));
        else value = 10'($urandom_range(1023, 3));
      end
      scpf_pkg::KIND_MOVE_SPD: begin
        if ($urandom_range(9) < 9) value = 10'($urandom_range(1023, 1));
        else value = 10'd0;
      end
      default: value = 10'($urandom_range(1023));
    endcase
    send_command(kind, 8'($urandom_range(255)), value);
  endtask

  initial begin
    sb         = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed commands: field extremes, each kind, every reject rule
    send_command(scpf_pkg::KIND_PING, 8'h00, 10'd0);
    send_command(scpf_pkg::KIND_PING, 8'hFF, 10'd1023);
    send_command(scpf_pkg::KIND_RESET, 8'h01, 10'h2AA);
    send_command(scpf_pkg::KIND_SET_ID, 8'h00, 10'd0);
    send_command(scpf_pkg::KIND_SET_ID, 8'hFF, 10'd255);
    send_command(scpf_pkg::KIND_SET_ID, 8'h12, 10'd256);
    send_command(scpf_pkg::KIND_SET_ID, 8'h34, 10'd1023);
    send_command(scpf_pkg::KIND_STATUS, 8'h05, 10'd0);
    send_command(scpf_pkg::KIND_STATUS, 8'hFE, 10'd2);
    send_command(scpf_pkg::KIND_STATUS, 8'h05, 10'd3);
    send_command(scpf_pkg::KIND_BAUD, 8'h01, 10'd1);
    send_command(scpf_pkg::KIND_BAUD, 8'h55, 10'd255);
    send_command(scpf_pkg::KIND_BAUD, 8'hAA, 10'd256);
    send_command(scpf_pkg::KIND_GOAL_POS, 8'h00, 10'd0);
    send_command(scpf_pkg::KIND_GOAL_POS, 8'hFF, 10'd1023);
    send_command(scpf_pkg::KIND_GOAL_POS, 8'hAA, 10'h155);
    send_command(scpf_pkg::KIND_MOVE_SPD, 8'h10, 10'd0);
    send_command(scpf_pkg::KIND_MOVE_SPD, 8'h20, 10'd1);
    send_command(scpf_pkg::KIND_MOVE_SPD, 8'hFF, 10'd1023);
    send_command(scpf_pkg::KIND_MOVE_SPD, 8'h55, 10'h2AA);
    send_command(scpf_pkg::KIND_UNUSED, 8'h00, 10'd0);
    send_command(scpf_pkg::KIND_UNUSED, 8'hFF, 10'd1023);

    // random commands under four idle and stall mixes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n == RANDOM_PER_PHASE / 2) wait_for_drain();
        send_random_command();
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d commands: %0d packets, %0d rejects, %0d bytes",
             sb.n_commands, sb.n_packets, sb.n_rejects, sb.n_bytes);
    $display("four idle/stall mixes, each with a full drain midway");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d bytes outstanding", sb.errors, sb.pending());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/scpf_pkg.sv
rtl/scpf_front.sv
rtl/scpf_queue.sv
rtl/scpf_back.sv
rtl/servo_command_packet_framer_core.sv
dv/servo_command_packet_framer_core_test.sv
